// ===== hdl/rht_pkg.sv =====
// shared types and constants for the reply holdoff table
package rht_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int ADDR_W      = 32;
	localparam int TIME_W      = 63;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int STATUS_W    = 2;
	localparam int USE_W       = 5;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	localparam logic OP_FIND = 1'b0;
	localparam logic OP_ADD  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ADDED     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] reply_to;
		logic [ADDR_W-1:0] hear_from;
		logic [TIME_W-1:0] expiry;
	} entry_t;

	// broadcast from the sequencer to every cell
	typedef struct packed {
		logic              collapse;
		logic              find;
		logic              add;
		logic [ADDR_W-1:0] reply_to;
		logic [ADDR_W-1:0] hear_from;
		logic [TIME_W-1:0] expiry;
		logic [TIME_W-1:0] now;
		logic [TIME_W-1:0] target;
	} ctl_t;

	// flags rippling up the chain from lower cells
	typedef struct packed {
		logic shift;
		logic found;
		logic valid;
	} chain_t;

endpackage

// ===== hdl/rht_cell.sv =====
// one table slot: holds an entry, collapses, matches and appends
module rht_cell
	import rht_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  ctl_t   ctl,
	input  entry_t upper,
	input  chain_t chain_in,
	output chain_t chain_out,
	output entry_t entry
);

	logic              valid_q;
	logic [ADDR_W-1:0] reply_to_q;
	logic [ADDR_W-1:0] hear_from_q;
	logic [TIME_W-1:0] expiry_q;
	logic              dead;
	logic              match;
	logic              hit;
	logic              take_add;

	assign dead     = valid_q && (expiry_q < ctl.now);
	assign match    = valid_q && (reply_to_q == ctl.reply_to) && (hear_from_q == ctl.hear_from);
	assign hit      = match && !chain_in.found;
	// first free slot sits right above the last valid one
	assign take_add = !valid_q && chain_in.valid;

	assign chain_out.shift = chain_in.shift | dead;
	assign chain_out.found = chain_in.found | match;
	assign chain_out.valid = valid_q;

	assign entry = '{valid: valid_q, reply_to: reply_to_q, hear_from: hear_from_q,
		expiry: expiry_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.collapse && chain_out.shift) begin
			valid_q <= upper.valid;
		end else if (ctl.add && take_add) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.collapse && chain_out.shift) begin
			reply_to_q  <= upper.reply_to;
			hear_from_q <= upper.hear_from;
			expiry_q    <= upper.expiry;
		end else if (ctl.add && take_add) begin
			reply_to_q  <= ctl.reply_to;
			hear_from_q <= ctl.hear_from;
			expiry_q    <= ctl.expiry;
		end else if (ctl.find && hit && (ctl.target > expiry_q)) begin
			expiry_q <= ctl.target;
		end
	end

endmodule

// ===== hdl/reply_holdoff_table.sv =====
// top level: sequencer, output register and the chain of table cells
// an add reaches its registered result through the add state; a lookup passes the
// purge state, the chain dropping one expired entry per cycle, then the find state
// throughput: one item at a time; the next item is accepted once the result is
// registered, even while it still waits on the output
// reset: asynchronous, clears every valid bit, the count and the sequencer
module reply_holdoff_table
	import rht_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// reply_to_addr[31:0], hear_from_addr[63:32], hold_time[126:64],
	// entry_expiry[189:127], now_time[252:190], zero fill[255:253]
	input  logic [255:0] s_axis_tdata,
	// op[0]
	input  logic [0:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// entries_in_use[4:0], zero fill[7:5]
	output logic [7:0]   m_axis_tdata,
	// status[1:0]
	output logic [1:0]   m_axis_tuser
);

	typedef enum logic [1:0] {S_IDLE, S_PURGE, S_FIND, S_ADD} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic              out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [USE_W-1:0]  use_q;
	logic [ADDR_W-1:0] reply_to_q;
	logic [ADDR_W-1:0] hear_from_q;
	logic [TIME_W-1:0] expiry_q;
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] target_q;

	logic [TIME_W:0]   sum;
	logic              in_acc;
	logic              out_free;
	ctl_t              ctl;
	entry_t            entries [TABLE_DEPTH];
	chain_t            chain   [TABLE_DEPTH+1];

	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);
	assign out_free      = !out_valid_q || m_axis_tready;
	assign sum           = {1'b0, s_axis_tdata[126:64]} + {1'b0, s_axis_tdata[252:190]};

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, use_q};
	assign m_axis_tuser  = status_q;

	assign ctl.collapse  = (state_q == S_PURGE) && chain[TABLE_DEPTH].shift;
	assign ctl.find      = (state_q == S_FIND) && out_free;
	assign ctl.add       = (state_q == S_ADD) && out_free;
	assign ctl.reply_to  = reply_to_q;
	assign ctl.hear_from = hear_from_q;
	assign ctl.expiry    = expiry_q;
	assign ctl.now       = now_q;
	assign ctl.target    = target_q;

	assign chain[0] = '{shift: 1'b0, found: 1'b0, valid: 1'b1};

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		entry_t upper;
		if (i == TABLE_DEPTH - 1) begin : g_top
			assign upper = '0;
		end else begin : g_mid
			assign upper = entries[i+1];
		end
		rht_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.upper     (upper),
			.chain_in  (chain[i]),
			.chain_out (chain[i+1]),
			.entry     (entries[i])
		);
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			reply_to_q  <= s_axis_tdata[31:0];
			hear_from_q <= s_axis_tdata[63:32];
			expiry_q    <= s_axis_tdata[189:127];
			now_q       <= s_axis_tdata[252:190];
			// saturate now + hold at the time maximum
			target_q    <= sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			status_q    <= ST_NOT_FOUND;
			use_q       <= '0;
		end else begin
			if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= (s_axis_tuser[0] == OP_ADD) ? S_ADD : S_PURGE;
					end
				end
				S_PURGE: begin
					// one expired entry leaves per cycle
					if (chain[TABLE_DEPTH].shift) begin
						count_q <= count_q - CNT_W'(1);
					end else begin
						state_q <= S_FIND;
					end
				end
				S_FIND: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						status_q    <= chain[TABLE_DEPTH].found ? ST_FOUND : ST_NOT_FOUND;
						use_q       <= USE_W'(count_q);
						state_q     <= S_IDLE;
					end
				end
				S_ADD: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (entries[TABLE_DEPTH-1].valid) begin
							status_q <= ST_FULL;
							use_q    <= USE_W'(count_q);
						end else begin
							status_q <= ST_ADDED;
							count_q  <= count_q + CNT_W'(1);
							use_q    <= USE_W'(count_q + CNT_W'(1));
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== tb/sv/reply_holdoff_table_tb.sv =====
// testbench for the reply holdoff table: directed and random lookups and adds checked item by item
`timescale 1ns / 100ps

module reply_holdoff_table_tb
	import rht_pkg::*;
();

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 1625;
	localparam int DRAIN_CYCLES = TABLE_DEPTH + 8;
	localparam int POOL_SIZE    = 6;
	localparam int PEND_DEPTH   = 64;

	localparam logic [ADDR_W-1:0] ADDR_ONES = '1;
	localparam logic [ADDR_W-1:0] PAIR_RTO  = 32'h0a00_0001;
	localparam logic [ADDR_W-1:0] PAIR_HFR  = 32'h0a00_0002;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [USE_W-1:0]    in_use;
	} outcome_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	// reply_to_addr, hear_from_addr, hold_time, entry_expiry, now_time, zero fill
	logic [255:0] s_axis_tdata = '0;
	// op
	logic [0:0]   s_axis_tuser = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	// entries_in_use, zero fill
	logic [7:0]   m_axis_tdata;
	// status
	logic [1:0]   m_axis_tuser;

	// behavioral copy of the table, valid entries packed at the low slots
	logic [ADDR_W-1:0] tbl_reply_to  [TABLE_DEPTH];
	logic [ADDR_W-1:0] tbl_hear_from [TABLE_DEPTH];
	logic [TIME_W-1:0] tbl_expiry    [TABLE_DEPTH];
	int                tbl_used = 0;

	// expected results in order of acceptance
	outcome_t pending [PEND_DEPTH];
	logic [5:0] pend_wr = '0;
	logic [5:0] pend_rd = '0;
	int       mismatches = 0;
	int       cycle_count = 0;
	int       stall_left = 0;
	bit       steady = 1'b0;   // no idling on either side while set

	reply_holdoff_table u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("tb: failure");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic logic [TIME_W-1:0] random_time();
		logic [63:0] raw;
		raw = {$urandom(), $urandom()};
		return raw[TIME_W-1:0];
	endfunction

	function automatic void report_mismatch(string what, longint unsigned want,
			longint unsigned got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch on %s: expected %0d, got %0d", what, want, got);
	endfunction

	// purge, find and update, or append; returns status and entry count
	function automatic outcome_t apply_to_table(logic op, logic [ADDR_W-1:0] rto,
			logic [ADDR_W-1:0] hfr, logic [TIME_W-1:0] hold,
			logic [TIME_W-1:0] exp_in, logic [TIME_W-1:0] now);
		int                keep;
		logic [TIME_W:0]   sum;
		logic [TIME_W-1:0] target;
		outcome_t          res;
		res.status = ST_NOT_FOUND;
		if (op == OP_FIND) begin
			keep = 0;
			for (int i = 0; i < tbl_used; i++) begin
				// equal to now still counts as live
				if (tbl_expiry[i] >= now) begin
					tbl_reply_to[keep]  = tbl_reply_to[i];
					tbl_hear_from[keep] = tbl_hear_from[i];
					tbl_expiry[keep]    = tbl_expiry[i];
					keep++;
				end
			end
			tbl_used = keep;
			sum = {1'b0, now} + {1'b0, hold};
			target = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
			for (int i = 0; i < tbl_used; i++) begin
				if (tbl_reply_to[i] == rto && tbl_hear_from[i] == hfr) begin
					if (target > tbl_expiry[i])
						tbl_expiry[i] = target;
					res.status = ST_FOUND;
					break;
				end
			end
		end else if (tbl_used < TABLE_DEPTH) begin
			tbl_reply_to[tbl_used]  = rto;
			tbl_hear_from[tbl_used] = hfr;
			tbl_expiry[tbl_used]    = exp_in;
			tbl_used++;
			res.status = ST_ADDED;
		end else begin
			res.status = ST_FULL;
		end
		res.in_use = USE_W'(tbl_used);
		return res;
	endfunction

	task automatic send_item(input logic op, input logic [ADDR_W-1:0] rto, hfr,
			input logic [TIME_W-1:0] hold, exp_in, now);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {3'b000, now, exp_in, hold, hfr, rto};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pending[pend_wr] = apply_to_table(op, rto, hfr, hold, exp_in, now);
		pend_wr = pend_wr + 6'd1;
	endtask

	// result side back-pressure
	always @(posedge clk) begin : result_stall
		int g;
		if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left--;
		end else begin
			g = pick_gap();
			m_axis_tready <= (g == 0);
			if (g > 0)
				stall_left = g - 1;
		end
	end

	always @(posedge clk) begin : check_results
		outcome_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pend_rd == pend_wr) begin
				report_mismatch("result with nothing pending", 64'd0, 64'(m_axis_tuser));
			end else begin
				want = pending[pend_rd];
				pend_rd = pend_rd + 6'd1;
				if (m_axis_tuser != want.status)
					report_mismatch("status", 64'(want.status), 64'(m_axis_tuser));
				if (m_axis_tdata != {3'b000, want.in_use})
					report_mismatch("entries_in_use", 64'(want.in_use),
						64'(m_axis_tdata));
			end
		end
	end

	task automatic test_empty_lookup();
		send_item(OP_FIND, '0, '0, '0, '0, '0);
	endtask

	task automatic test_fill_and_full();
		send_item(OP_ADD, '0, '0, TIME_MAX, 63'd100, '0);
		// add at a late now: nothing may be purged here
		send_item(OP_ADD, ADDR_ONES, '0, '0, 63'd99, TIME_MAX);
		send_item(OP_ADD, ADDR_ONES, ADDR_ONES, '0, TIME_MAX - 1, '0);
		send_item(OP_ADD, PAIR_RTO, PAIR_HFR, '0, 63'd2000, '0);
		send_item(OP_ADD, PAIR_RTO, PAIR_HFR, '0, 63'd500, '0);
		send_item(OP_ADD, '0, ADDR_ONES, '0, '0, '0);
		for (int k = 6; k < TABLE_DEPTH; k++)
			send_item(OP_ADD, 32'hc0a8_0000 + k, 32'hc0a8_0100 + k, '0,
				(k == TABLE_DEPTH - 1) ? TIME_MAX : 63'(1000 + k), '0);
		// no room left
		send_item(OP_ADD, 32'h1, 32'h1, '0, '0, '0);
	endtask

	task automatic test_expiry_boundary();
		// drops the entries expiring at 99 and 0, keeps the one at exactly 100
		send_item(OP_FIND, '0, '0, '0, '0, 63'd100);
	endtask

	task automatic test_duplicate_pairs();
		// only the older of the two copies is raised
		send_item(OP_FIND, PAIR_RTO, PAIR_HFR, 63'd5000, '0, 63'd200);
		send_item(OP_FIND, PAIR_RTO, PAIR_HFR, '0, '0, 63'd1500);
		send_item(OP_FIND, PAIR_RTO, PAIR_HFR, '0, '0, 63'd2001);
	endtask

	task automatic test_saturation();
		send_item(OP_FIND, ADDR_ONES, ADDR_ONES, TIME_MAX, '0, 63'd3000);
		send_item(OP_FIND, ADDR_ONES, ADDR_ONES, TIME_MAX, TIME_MAX, TIME_MAX);
	endtask

	task automatic test_random_traffic(input int count);
		logic [ADDR_W-1:0] pool_rto [POOL_SIZE];
		logic [ADDR_W-1:0] pool_hfr [POOL_SIZE];
		logic [ADDR_W-1:0] rto;
		logic [ADDR_W-1:0] hfr;
		logic [TIME_W-1:0] clock_now;
		logic [TIME_W-1:0] hold;
		logic [TIME_W-1:0] exp_in;
		int                add_share;
		int                pick;
		int                r;
		for (int i = 0; i < POOL_SIZE; i++) begin
			pool_rto[i] = $urandom;
			pool_hfr[i] = $urandom;
		end
		clock_now = 63'd10;
		add_share = 50;
		for (int n = 0; n < count; n++) begin
			if (n % 100 == 0) begin
				add_share = $urandom_range(25, 70);
				steady = ($urandom_range(0, 3) == 0);
			end
			// rare jumps of the time base, some close to the top to hit saturation
			if ($urandom_range(0, 99) == 0)
				clock_now = $urandom_range(0, 1) ? random_time()
					: TIME_MAX - TIME_W'($urandom_range(0, 2000));
			pick = $urandom_range(0, POOL_SIZE - 1);
			rto = pool_rto[pick];
			hfr = pool_hfr[pick];
			if ($urandom_range(0, 9) == 0) begin
				rto = $urandom;
				hfr = $urandom;
			end else if ($urandom_range(0, 19) == 0) begin
				// one address matches, the other does not
				hfr = pool_hfr[(pick + 1) % POOL_SIZE];
			end
			hold = ($urandom_range(0, 19) == 0) ? random_time()
				: TIME_W'($urandom_range(0, 300));
			r = $urandom_range(0, 99);
			if (r < 8) begin
				send_item(1'($urandom), $urandom, $urandom, random_time(), random_time(),
					random_time());
			end else if (r < add_share + 8) begin
				exp_in = ($urandom_range(0, 19) == 0) ? random_time()
					: clock_now + TIME_W'($urandom_range(0, 400));
				send_item(OP_ADD, rto, hfr, hold, exp_in, clock_now);
			end else begin
				send_item(OP_FIND, rto, hfr, hold, random_time(), clock_now);
				clock_now = clock_now + TIME_W'($urandom_range(0, 60));
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_lookup();
		test_fill_and_full();
		test_expiry_boundary();
		test_duplicate_pairs();
		test_saturation();
		test_random_traffic(RANDOM_ITEMS);
		s_axis_tvalid <= 1'b0;
		while (pend_rd != pend_wr) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pend_rd == pend_wr)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
